[sv/sha224_hash_engine_defines.svh]
// assertion macros shared by the sha224 engine rtl
// no dependencies
`ifndef SHA224_HASH_ENGINE_DEFINES_SVH
`define SHA224_HASH_ENGINE_DEFINES_SVH
// property must hold after a trigger in the same cycle
`define SHA_ASSERT_IMP(lbl, trig, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
        else $error("assertion failed");
// property must hold in the cycle after a trigger
`define SHA_ASSERT_NEXT(lbl, trig, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error("assertion failed");
`endif

[sv/sha224_pkg.sv]
// sha224 package: round constants, initial hash, queue entry type, state enums
// no dependencies
`default_nettype none
package sha224_pkg;

    // queue entry between front end and compression back end
    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } sha_entry_t;

    typedef enum logic [2:0] {
        BE_LOAD,
        BE_ROUND,
        BE_ADD,
        BE_OUT
    } be_state_t;

    typedef enum logic [1:0] {
        FE_IDLE,
        FE_EXTRA,
        FE_ZERO,
        FE_LEN
    } fe_state_t;

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        case (t)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] i);
        logic [31:0] h;
        case (i)
            3'd0: h = 32'hc1059ed8; 3'd1: h = 32'h367cd507;
            3'd2: h = 32'h3070dd17; 3'd3: h = 32'hf70e5939;
            3'd4: h = 32'hffc00b31; 3'd5: h = 32'h68581511;
            3'd6: h = 32'h64f98fa7;
            default: h = 32'hbefa4fa4;
        endcase
        return h;
    endfunction

endpackage
`default_nettype wire

[sv/sha224_front.sv]
// front end: pads the message, counts bits, emits one schedule word per cycle while the queue does not stall
// depends on sha224_pkg and sha224_hash_engine_defines.svh
`default_nettype none
`include "sha224_hash_engine_defines.svh"
module sha224_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [31:0]           msg_word,
    input  wire logic [2:0]            valid_bytes,
    input  wire logic                  final_word,
    output logic                       q_valid,
    input  wire logic                  q_stall,
    output sha224_pkg::sha_entry_t     q_data
);

    sha224_pkg::fe_state_t state_reg, state_next;
    logic [63:0] len_reg, len_next;
    logic [3:0]  pos_reg, pos_next;
    logic        lenlo_reg, lenlo_next;
    logic [2:0]  nb;
    logic [31:0] keep, padw;
    logic        push;

    // clamp byte count and build the padded final word
    always_comb
    begin
        nb = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
        case (nb)
            3'd0: keep = 32'h00000000;
            3'd1: keep = 32'hff000000;
            3'd2: keep = 32'hffff0000;
            3'd3: keep = 32'hffffff00;
            default: keep = 32'hffffffff;
        endcase
        case (nb)
            3'd0: padw = 32'h80000000;
            3'd1: padw = 32'h00800000;
            3'd2: padw = 32'h00008000;
            3'd3: padw = 32'h00000080;
            default: padw = 32'h0;
        endcase
    end

    assign push = q_valid && !q_stall;

    // padding sequencer
    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        lenlo_next = lenlo_reg;
        q_valid    = 1'b0;
        q_data     = '0;
        in_stall   = 1'b1;
        case (state_reg)
            sha224_pkg::FE_IDLE:
            begin
                in_stall = q_stall;
                q_valid  = in_valid;
                if (!final_word)
                begin
                    q_data.word = msg_word;
                end
                else
                begin
                    q_data.word = (nb == 3'd4) ? msg_word : ((msg_word & keep) | padw);
                end
                if (push)
                begin
                    pos_next = pos_reg + 4'd1;
                    if (!final_word)
                    begin
                        len_next = len_reg + 64'd32;
                    end
                    else
                    begin
                        len_next = len_reg + {58'd0, nb, 3'd0};
                        if (nb == 3'd4)
                            state_next = sha224_pkg::FE_EXTRA;
                        else
                            state_next = sha224_pkg::FE_ZERO;
                    end
                end
            end
            sha224_pkg::FE_EXTRA:
            begin
                q_valid     = 1'b1;
                q_data.word = 32'h80000000;
                if (push)
                begin
                    pos_next   = pos_reg + 4'd1;
                    state_next = sha224_pkg::FE_ZERO;
                end
            end
            sha224_pkg::FE_ZERO:
            begin
                if (pos_reg == 4'd14)
                begin
                    state_next = sha224_pkg::FE_LEN;
                    lenlo_next = 1'b0;
                end
                else
                begin
                    q_valid = 1'b1;
                    if (push)
                        pos_next = pos_reg + 4'd1;
                end
            end
            sha224_pkg::FE_LEN:
            begin
                q_valid     = 1'b1;
                q_data.word = lenlo_reg ? len_reg[31:0] : len_reg[63:32];
                q_data.last = lenlo_reg;
                if (push)
                begin
                    pos_next   = pos_reg + 4'd1;
                    lenlo_next = 1'b1;
                    if (lenlo_reg)
                    begin
                        state_next = sha224_pkg::FE_IDLE;
                        len_next   = '0;
                        pos_next   = '0;
                    end
                end
            end
            default:
            begin
                state_next = sha224_pkg::FE_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha224_pkg::FE_IDLE;
            len_reg   <= '0;
            pos_reg   <= '0;
            lenlo_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            lenlo_reg <= lenlo_next;
        end
    end

    // the last-of-message marker only goes out at block position fifteen
    `SHA_ASSERT_IMP(a_last_pos, push && q_data.last, pos_reg == 4'd15)
    // no new input is taken while padding runs
    `SHA_ASSERT_IMP(a_no_take, state_reg != sha224_pkg::FE_IDLE, in_stall)
    // message words pass straight through when idle
    `SHA_ASSERT_IMP(a_idle_pass, state_reg == sha224_pkg::FE_IDLE, q_valid == in_valid)

endmodule
`default_nettype wire

[sv/sha224_queue.sv]
// short two-entry queue between front end and back end
// depends on sha224_pkg and sha224_hash_engine_defines.svh
`default_nettype none
`include "sha224_hash_engine_defines.svh"
module sha224_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_valid,
    output logic                   wr_stall,
    input  wire sha224_pkg::sha_entry_t wr_data,
    output logic                   rd_valid,
    input  wire logic              rd_stall,
    output sha224_pkg::sha_entry_t rd_data
);

    sha224_pkg::sha_entry_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_stall = (cnt_reg == 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && !wr_stall;
    assign rd = rd_valid && !rd_stall;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= ~wp_reg;
            if (rd)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    `SHA_ASSERT_IMP(a_cnt_range, 1'b1, cnt_reg != 2'd3)
    `SHA_ASSERT_NEXT(a_cnt_full, wr && !rd && cnt_reg == 2'd1, wr_stall)
    `SHA_ASSERT_IMP(a_empty_idle, cnt_reg == 2'd0, !rd_valid)

endmodule
`default_nettype wire

[sv/sha224_back.sv]
// back end: schedule window, 64-round compression, digest output
// depends on sha224_pkg and sha224_hash_engine_defines.svh
`default_nettype none
`include "sha224_hash_engine_defines.svh"
module sha224_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   q_valid,
    output logic                        q_stall,
    input  wire sha224_pkg::sha_entry_t q_data,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [31:0]                 digest_word,
    output logic [2:0]                  word_index,
    output logic                        last_of_digest
);

    sha224_pkg::be_state_t state_reg, state_next;
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [3:0]  pos_reg, pos_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic        fin_reg, fin_next;
    logic [2:0]  oi_reg, oi_next;
    logic        take;
    logic        rnd_end;
    logic [31:0] wt, t1, t2, s0, s1, ws0, ws1, ch, maj;

    assign take = q_valid && !q_stall;
    assign rnd_end = (state_reg == sha224_pkg::BE_ROUND) && (rnd_reg == 6'd63);

    // message expansion and round function, one round per cycle
    always_comb
    begin
        ws1 = {w_reg[14][16:0], w_reg[14][31:17]} ^ {w_reg[14][18:0], w_reg[14][31:19]}
            ^ (w_reg[14] >> 10);
        ws0 = {w_reg[1][6:0], w_reg[1][31:7]} ^ {w_reg[1][17:0], w_reg[1][31:18]}
            ^ (w_reg[1] >> 3);
        wt  = (rnd_reg < 6'd16) ? w_reg[0] : (ws1 + w_reg[9] + ws0 + w_reg[0]);
        s1  = {v_reg[4][5:0], v_reg[4][31:6]} ^ {v_reg[4][10:0], v_reg[4][31:11]}
            ^ {v_reg[4][24:0], v_reg[4][31:25]};
        ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        s0  = {v_reg[0][1:0], v_reg[0][31:2]} ^ {v_reg[0][12:0], v_reg[0][31:13]}
            ^ {v_reg[0][21:0], v_reg[0][31:22]};
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1  = v_reg[7] + s1 + ch + sha224_pkg::round_k(rnd_reg) + wt;
        t2  = s0 + maj;
    end

    // control sequencer
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        rnd_next   = rnd_reg;
        fin_next   = fin_reg;
        oi_next    = oi_reg;
        q_stall    = 1'b1;
        out_valid  = 1'b0;
        case (state_reg)
            sha224_pkg::BE_LOAD:
            begin
                q_stall = 1'b0;
                if (take)
                begin
                    pos_next = pos_reg + 4'd1;
                    if (pos_reg == 4'd15)
                    begin
                        fin_next   = q_data.last;
                        rnd_next   = '0;
                        state_next = sha224_pkg::BE_ROUND;
                    end
                end
            end
            sha224_pkg::BE_ROUND:
            begin
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                    state_next = sha224_pkg::BE_ADD;
            end
            sha224_pkg::BE_ADD:
            begin
                oi_next    = '0;
                state_next = fin_reg ? sha224_pkg::BE_OUT : sha224_pkg::BE_LOAD;
            end
            sha224_pkg::BE_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    oi_next = oi_reg + 3'd1;
                    if (oi_reg == 3'd6)
                        state_next = sha224_pkg::BE_LOAD;
                end
            end
            default:
            begin
                state_next = sha224_pkg::BE_LOAD;
            end
        endcase
    end

    assign digest_word    = h_reg[oi_reg];
    assign word_index     = oi_reg;
    assign last_of_digest = (oi_reg == 3'd6);

    // schedule window: shift in on load, shift with expansion during rounds
    always_ff @(posedge clk)
    begin
        if (take || state_reg == sha224_pkg::BE_ROUND)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= (state_reg == sha224_pkg::BE_ROUND) ? wt : q_data.word;
        end
    end

    // working variables and chaining state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha224_pkg::BE_LOAD;
            pos_reg   <= '0;
            rnd_reg   <= '0;
            fin_reg   <= 1'b0;
            oi_reg    <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha224_pkg::init_h(3'(i));
                v_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            rnd_reg   <= rnd_next;
            fin_reg   <= fin_next;
            oi_reg    <= oi_next;
            if (take && pos_reg == 4'd15)
            begin
                for (int i = 0; i < 8; i++)
                    v_reg[i] <= h_reg[i];
            end
            else if (state_reg == sha224_pkg::BE_ROUND)
            begin
                for (int i = 1; i < 4; i++)
                    v_reg[i] <= v_reg[i - 1];
                for (int i = 5; i < 8; i++)
                    v_reg[i] <= v_reg[i - 1];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[0] <= t1 + t2;
            end
            if (state_reg == sha224_pkg::BE_ADD)
            begin
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= h_reg[i] + v_reg[i];
            end
            if (state_reg == sha224_pkg::BE_OUT && !out_stall && oi_reg == 3'd6)
            begin
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= sha224_pkg::init_h(3'(i));
            end
        end
    end

    `SHA_ASSERT_IMP(a_idle_load, state_reg != sha224_pkg::BE_LOAD, q_stall)
    `SHA_ASSERT_NEXT(a_round_end, rnd_end, state_reg == sha224_pkg::BE_ADD)
    `SHA_ASSERT_IMP(a_out_pos, out_valid, pos_reg == 4'd0)

endmodule
`default_nettype wire

[sv/sha224_hash_engine.sv]
// sha224 engine: each 512-bit block is loaded, run through 64 rounds and added into the
// chaining state by the single round unit, which takes no new block words until it is done
// final word: the front end pads the block, spilling into one block more when padding
// does not fit; the seven digest items leave one per cycle while out_stall is low
// rst_n asynchronous active low restores the initial hash and clears counters
// depends on sha224_pkg, sha224_front, sha224_queue, sha224_back
`default_nettype none
module sha224_hash_engine (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] msg_word,
    input  wire logic [2:0]  valid_bytes,
    input  wire logic        final_word,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_of_digest
);

    sha224_pkg::sha_entry_t fq_data, qb_data;
    logic fq_valid, fq_stall, qb_valid, qb_stall;

    // padding front end
    sha224_front u_front (
        .clk, .rst_n, .in_valid, .in_stall, .msg_word, .valid_bytes, .final_word,
        .q_valid(fq_valid), .q_stall(fq_stall), .q_data(fq_data)
    );

    // decoupling queue
    sha224_queue u_queue (
        .clk, .rst_n,
        .wr_valid(fq_valid), .wr_stall(fq_stall), .wr_data(fq_data),
        .rd_valid(qb_valid), .rd_stall(qb_stall), .rd_data(qb_data)
    );

    // compression back end
    sha224_back u_back (
        .clk, .rst_n,
        .q_valid(qb_valid), .q_stall(qb_stall), .q_data(qb_data),
        .out_valid, .out_stall, .digest_word, .word_index, .last_of_digest
    );

endmodule
`default_nettype wire
